[hw/rtl/ldf_pkg.sv]
// ----------------------------------------------------------------------------
// ldf_pkg
// shared types, constants and header layout helpers for the ledger deframer
// ----------------------------------------------------------------------------
package ldf_pkg;

	localparam int unsigned HEADER_BYTES = 152;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam logic [15:0] MAX_RECORDS_RESET = 16'd1024;
	localparam logic [7:0] GOOD_VERSION = 8'h01;

	typedef enum logic [3:0] {
		SEC_MAGIC       = 4'd0,
		SEC_VERSION     = 4'd1,
		SEC_FLAGS       = 4'd2,
		SEC_EVENTLEN    = 4'd3,
		SEC_DATALEN     = 4'd4,
		SEC_METALEN     = 4'd5,
		SEC_TIME        = 4'd6,
		SEC_PREVHASH    = 4'd7,
		SEC_CONTENTHASH = 4'd8,
		SEC_SIGNATURE   = 4'd9,
		SEC_EVENT       = 4'd10,
		SEC_PAYLOAD     = 4'd11,
		SEC_META        = 4'd12
	} sec_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_MAGIC   = 2'd1,
		ST_BAD_VERSION = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [3:0]  sec;
		logic [31:0] off;
		logic        fdone;
		logic [63:0] fval;
		logic        rend;
		status_t     rstat;
		logic [15:0] ridx;
	} result_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

	// first header position of a section; body sections map to the header end
	function automatic logic [7:0] sec_start(input sec_t s);
		logic [7:0] p;
		case (s)
			SEC_MAGIC:       p = 8'd0;
			SEC_VERSION:     p = 8'd4;
			SEC_FLAGS:       p = 8'd5;
			SEC_EVENTLEN:    p = 8'd6;
			SEC_DATALEN:     p = 8'd8;
			SEC_METALEN:     p = 8'd12;
			SEC_TIME:        p = 8'd16;
			SEC_PREVHASH:    p = 8'd24;
			SEC_CONTENTHASH: p = 8'd56;
			SEC_SIGNATURE:   p = 8'd88;
			default:         p = 8'(HEADER_BYTES);
		endcase
		return p;
	endfunction

	function automatic sec_t hdr_sec(input logic [7:0] pos);
		sec_t s;
		if (pos < 8'd4) s = SEC_MAGIC;
		else if (pos < 8'd5) s = SEC_VERSION;
		else if (pos < 8'd6) s = SEC_FLAGS;
		else if (pos < 8'd8) s = SEC_EVENTLEN;
		else if (pos < 8'd12) s = SEC_DATALEN;
		else if (pos < 8'd16) s = SEC_METALEN;
		else if (pos < 8'd24) s = SEC_TIME;
		else if (pos < 8'd56) s = SEC_PREVHASH;
		else if (pos < 8'd88) s = SEC_CONTENTHASH;
		else s = SEC_SIGNATURE;
		return s;
	endfunction

	// "WORM"
	function automatic logic [7:0] magic_byte(input logic [1:0] i);
		logic [7:0] m;
		case (i)
			2'd0:    m = 8'h57;
			2'd1:    m = 8'h4F;
			2'd2:    m = 8'h52;
			default: m = 8'h4D;
		endcase
		return m;
	endfunction

endpackage

[hw/rtl/ldf_front.sv]
// ----------------------------------------------------------------------------
// ldf_front
// takes stream bytes, tracks framing, builds a tagged word per byte under limit
// ----------------------------------------------------------------------------
module ldf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [15:0]     max_records,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      stream_byte,
	input  ldf_pkg::qstat_t qstat,
	output logic            push,
	output ldf_pkg::result_t push_data
);
	import ldf_pkg::*;

	logic [15:0] max_q;
	sec_t        sec_q;
	logic [7:0]  hp_q;
	logic [31:0] bp_q;
	logic [15:0] ev_len_q;
	logic [31:0] pl_len_q;
	logic [31:0] md_len_q;
	logic [63:0] acc_q;
	status_t     pend_q;
	logic [15:0] cnt_q;

	sec_t        sec_d;
	logic [7:0]  hp_d;
	logic [31:0] bp_d;
	logic [15:0] ev_len_d;
	logic [31:0] pl_len_d;
	logic [31:0] md_len_d;
	logic [63:0] acc_d;
	status_t     pend_d;
	logic [15:0] cnt_d;

	sec_t        hsec;
	logic [7:0]  hoff;
	logic [7:0]  hp_inc;
	logic [63:0] acc_new;
	logic [31:0] blen;
	logic        rend;
	logic        active;
	result_t     res;

	assign in_ready = !qstat.full;
	assign active = in_valid && in_ready && (cnt_q < max_q);
	assign push = active;
	assign push_data = res;

	always_comb begin
		sec_d = sec_q;
		hp_d = hp_q;
		bp_d = bp_q;
		ev_len_d = ev_len_q;
		pl_len_d = pl_len_q;
		md_len_d = md_len_q;
		acc_d = acc_q;
		pend_d = pend_q;
		cnt_d = cnt_q;
		rend = 1'b0;
		hsec = hdr_sec(hp_q);
		hoff = hp_q - sec_start(hsec);
		hp_inc = hp_q + 8'd1;
		acc_new = acc_q | (64'(stream_byte) << {hoff[2:0], 3'b000});
		case (sec_q)
			SEC_EVENT:   blen = 32'(ev_len_q);
			SEC_PAYLOAD: blen = pl_len_q;
			SEC_META:    blen = md_len_q;
			default:     blen = '0;
		endcase
		res.data = stream_byte;
		res.sec = hsec;
		res.off = 32'(hoff);
		res.fdone = 1'b0;
		res.fval = '0;
		res.rend = 1'b0;
		res.rstat = ST_OK;
		res.ridx = cnt_q;

		if (sec_q != SEC_EVENT && sec_q != SEC_PAYLOAD && sec_q != SEC_META) begin
			if (hp_q < 8'd4 && stream_byte != magic_byte(hp_q[1:0]) && pend_q == ST_OK) begin
				pend_d = ST_BAD_MAGIC;
			end
			if (hp_q == 8'd4 && stream_byte != GOOD_VERSION && pend_q == ST_OK) begin
				pend_d = ST_BAD_VERSION;
			end
			if (hsec == SEC_EVENTLEN || hsec == SEC_DATALEN || hsec == SEC_METALEN ||
				hsec == SEC_TIME) begin
				acc_d = acc_new;
				if (hp_inc == sec_start(sec_t'(hsec + 4'd1))) begin
					res.fdone = 1'b1;
					res.fval = acc_new;
					if (hsec == SEC_EVENTLEN) ev_len_d = acc_new[15:0];
					if (hsec == SEC_DATALEN) pl_len_d = acc_new[31:0];
					if (hsec == SEC_METALEN) md_len_d = acc_new[31:0];
					acc_d = '0;
				end
			end
			hp_d = hp_inc;
			sec_d = hdr_sec(hp_inc);
			if (hp_inc == 8'(HEADER_BYTES)) begin
				hp_d = '0;
				bp_d = '0;
				if (ev_len_q != '0) sec_d = SEC_EVENT;
				else if (pl_len_q != '0) sec_d = SEC_PAYLOAD;
				else if (md_len_q != '0) sec_d = SEC_META;
				else rend = 1'b1;
			end
		end else begin
			res.sec = sec_q;
			res.off = bp_q;
			bp_d = bp_q + 32'd1;
			if ({1'b0, bp_q} + 33'd1 >= {1'b0, blen}) begin
				bp_d = '0;
				if (sec_q == SEC_EVENT && pl_len_q != '0) sec_d = SEC_PAYLOAD;
				else if (sec_q != SEC_META && md_len_q != '0) sec_d = SEC_META;
				else rend = 1'b1;
			end
		end

		if (rend) begin
			res.rend = 1'b1;
			res.rstat = pend_d;
			if (pend_d == ST_OK) cnt_d = cnt_q + 16'd1;
			pend_d = ST_OK;
			sec_d = SEC_MAGIC;
			hp_d = '0;
			bp_d = '0;
			acc_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RECORDS_RESET;
			sec_q <= SEC_MAGIC;
			hp_q <= '0;
			bp_q <= '0;
			ev_len_q <= '0;
			pl_len_q <= '0;
			md_len_q <= '0;
			acc_q <= '0;
			pend_q <= ST_OK;
			cnt_q <= '0;
		end else begin
			if (cfg_valid) begin
				max_q <= max_records;
			end
			if (active) begin
				sec_q <= sec_d;
				hp_q <= hp_d;
				bp_q <= bp_d;
				ev_len_q <= ev_len_d;
				pl_len_q <= pl_len_d;
				md_len_q <= md_len_d;
				acc_q <= acc_d;
				pend_q <= pend_d;
				cnt_q <= cnt_d;
			end
		end
	end

endmodule

[hw/rtl/ldf_queue.sv]
// ----------------------------------------------------------------------------
// ldf_queue
// short word queue between the framing front and the output back
// ----------------------------------------------------------------------------
module ldf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ldf_pkg::result_t push_data,
	input  logic             pop,
	output ldf_pkg::result_t pop_data,
	output ldf_pkg::qstat_t  qstat
);
	import ldf_pkg::*;

	localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

	result_t         mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   count_q;

	assign qstat.full = (count_q == (PtrW+1)'(QUEUE_DEPTH));
	assign qstat.nonempty = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/ldf_back.sv]
// ----------------------------------------------------------------------------
// ldf_back
// output register stage that pulls words from the queue and offers them
// ----------------------------------------------------------------------------
module ldf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ldf_pkg::qstat_t  qstat,
	input  ldf_pkg::result_t pop_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output ldf_pkg::result_t out_data
);
	import ldf_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign pop = qstat.nonempty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= qstat.nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= pop_data;
		end
	end

endmodule

[hw/rtl/ledger_record_deframer.sv]
// an accepted byte is written into the queue, then into the output register
// throughput: one byte per cycle while the queue has room, set by the framing counters
// a byte taken while the record limit is reached is consumed with no word out
// reset: framing restarts at the magic field, counters clear, limit is 1024
// ----------------------------------------------------------------------------
// ledger_record_deframer
// frames a stream of ledger records and tags each byte with section and offset
// ----------------------------------------------------------------------------
module ledger_record_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] max_records,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [3:0]  section,
	output logic [31:0] section_offset,
	output logic        field_done,
	output logic [63:0] field_value,
	output logic        record_end,
	output logic [1:0]  record_status,
	output logic [15:0] record_index
);
	import ldf_pkg::*;

	qstat_t  qstat;
	logic    push;
	logic    pop;
	result_t push_data;
	result_t pop_data;
	result_t out_data;

	assign cfg_ready = 1'b1;

	ldf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.max_records (max_records),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	ldf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	ldf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.pop_data  (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign out_byte = out_data.data;
	assign section = out_data.sec;
	assign section_offset = out_data.off;
	assign field_done = out_data.fdone;
	assign field_value = out_data.fval;
	assign record_end = out_data.rend;
	assign record_status = out_data.rstat;
	assign record_index = out_data.ridx;

`ifndef SYNTHESIS
	a_end_sec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_end |-> section == SEC_SIGNATURE || section == SEC_EVENT ||
			section == SEC_PAYLOAD || section == SEC_META)
		else $error("record end outside signature or body");

	a_field_sec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && field_done |-> section == SEC_EVENTLEN || section == SEC_DATALEN ||
			section == SEC_METALEN || section == SEC_TIME)
		else $error("field done outside numeric field");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !record_end |-> record_status == ST_OK)
		else $error("status set without record end");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> qstat.full && qstat.nonempty)
		else $error("input stalled with room in queue");
`endif

endmodule

[dv/ledger_record_deframer_tb.sv]
// ----------------------------------------------------------------------------
// ledger_record_deframer_tb
// Sends back-to-back ledger records through the deframer. Most records are
// well formed with short random bodies, and some have a bad magic or a bad
// version. A tracker class keeps its own framing state, tags every byte it
// expects to come out, and compares each output word field by field. The
// record limit is moved through its extremes, including a freeze partway
// through a record. Both sides stall at random, and the receiver holds off
// for a long stretch once.
// ----------------------------------------------------------------------------
module ledger_record_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ldf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AT = 400;
	localparam int HOLD_CYCLES = 300;
	localparam logic [31:0] MAGIC_LE = 32'h4D52_4F57;

	class ledger_tracker;
		result_t pending_words[$];
		int mismatches;
		logic [15:0] limit;
		logic [15:0] accepted;
		sec_t cur_sec;
		logic [7:0] hdr_pos;
		logic [31:0] body_pos;
		logic [15:0] ev_len;
		logic [31:0] pay_len;
		logic [31:0] metadata_bytes;
		logic [63:0] acc;
		status_t status;

		function new();
			mismatches = 0;
			limit = MAX_RECORDS_RESET;
			accepted = '0;
			cur_sec = SEC_MAGIC;
			hdr_pos = '0;
			body_pos = '0;
			ev_len = '0;
			pay_len = '0;
			metadata_bytes = '0;
			acc = '0;
			status = ST_OK;
		endfunction

		function int unsigned sec_first(int s);
			case (s)
				0: return 0;
				1: return 4;
				2: return 5;
				3: return 6;
				4: return 8;
				5: return 12;
				6: return 16;
				7: return 24;
				8: return 56;
				9: return 88;
				default: return HEADER_BYTES;
			endcase
		endfunction

		function int header_sec(int unsigned pos);
			int s;
			s = 0;
			while (s < 9 && pos >= sec_first(s + 1)) s++;
			return s;
		endfunction

		function logic [31:0] body_len(sec_t s);
			case (s)
				SEC_EVENT: return 32'(ev_len);
				SEC_PAYLOAD: return pay_len;
				SEC_META: return metadata_bytes;
				default: return '0;
			endcase
		endfunction

		// first non-empty body after the given section
		function bit next_body(input int after, output sec_t nxt);
			nxt = SEC_MAGIC;
			for (int s = after + 1; s <= int'(SEC_META); s++) begin
				if (s >= int'(SEC_EVENT) && body_len(sec_t'(s)) != 0) begin
					nxt = sec_t'(s);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void take_byte(logic [7:0] b);
			result_t w;
			int unsigned hp;
			int s;
			sec_t nxt;
			logic [31:0] off;
			bit rend;
			if (accepted >= limit) return;
			w = '0;
			w.data = b;
			w.ridx = accepted;
			rend = 1'b0;
			if (cur_sec < SEC_EVENT) begin
				hp = hdr_pos;
				if (hp >= HEADER_BYTES) hp = 0;
				s = header_sec(hp);
				off = hp - sec_first(s);
				if (hp < 4 && b != MAGIC_LE[8 * hp +: 8] && status == ST_OK)
					status = ST_BAD_MAGIC;
				if (hp == 4 && b != GOOD_VERSION && status == ST_OK)
					status = ST_BAD_VERSION;
				if (s >= int'(SEC_EVENTLEN) && s <= int'(SEC_TIME)) begin
					acc |= 64'(b) << ((off % 8) * 8);
					if (hp + 1 == sec_first(s + 1)) begin
						w.fdone = 1'b1;
						w.fval = acc;
						case (sec_t'(s))
							SEC_EVENTLEN: ev_len = acc[15:0];
							SEC_DATALEN: pay_len = acc[31:0];
							SEC_METALEN: metadata_bytes = acc[31:0];
							default: ;
						endcase
						acc = '0;
					end
				end
				w.sec = 4'(s);
				w.off = off;
				hp++;
				if (hp >= HEADER_BYTES) begin
					hdr_pos = '0;
					if (next_body(SEC_SIGNATURE, nxt)) begin
						cur_sec = nxt;
						body_pos = '0;
					end else begin
						rend = 1'b1;
					end
				end else begin
					hdr_pos = 8'(hp);
					cur_sec = sec_t'(header_sec(hp));
				end
			end else begin
				w.sec = cur_sec;
				w.off = body_pos;
				body_pos++;
				if (body_pos >= body_len(cur_sec)) begin
					body_pos = '0;
					if (next_body(cur_sec, nxt)) cur_sec = nxt;
					else rend = 1'b1;
				end
			end
			if (rend) begin
				w.rend = 1'b1;
				w.rstat = status;
				if (status == ST_OK) accepted++;
				status = ST_OK;
				cur_sec = SEC_MAGIC;
				hdr_pos = '0;
				body_pos = '0;
				acc = '0;
			end
			pending_words.push_back(w);
		endfunction

		function void same(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_word(result_t got);
			result_t want;
			if (pending_words.size() == 0) begin
				$error("word with nothing expected: out_byte %0h section %0d",
					got.data, got.sec);
				mismatches++;
				return;
			end
			want = pending_words.pop_front();
			same("out_byte", want.data, got.data);
			same("section", want.sec, got.sec);
			same("section_offset", want.off, got.off);
			same("field_done", want.fdone, got.fdone);
			same("field_value", want.fval, got.fval);
			same("record_end", want.rend, got.rend);
			same("record_status", want.rstat, got.rstat);
			same("record_index", want.ridx, got.ridx);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] max_records;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  stream_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic [3:0]  section;
	logic [31:0] section_offset;
	logic        field_done;
	logic [63:0] field_value;
	logic        record_end;
	logic [1:0]  record_status;
	logic [15:0] record_index;

	ledger_tracker tracker = new();
	logic [7:0] rec_q[$];
	int send_gap_pct = 8;
	int recv_gap_pct = 67;
	int bytes_taken = 0;

	ledger_record_deframer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.max_records    (max_records),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.stream_byte    (stream_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.section        (section),
		.section_offset (section_offset),
		.field_done     (field_done),
		.field_value    (field_value),
		.record_end     (record_end),
		.record_status  (record_status),
		.record_index   (record_index)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin : monitor
		result_t seen;
		if (cfg_valid && cfg_ready) tracker.limit = max_records;
		if (in_valid && in_ready) begin
			tracker.take_byte(stream_byte);
			bytes_taken++;
		end
		if (out_valid && out_ready) begin
			seen = '{data: out_byte, sec: section, off: section_offset,
				fdone: field_done, fval: field_value, rend: record_end,
				rstat: status_t'(record_status), ridx: record_index};
			tracker.check_word(seen);
		end
	end

	// random stalls, plus one long hold-off so the block backs up
	initial begin : receiver
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && bytes_taken >= HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ledger_record_deframer: mismatch");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_span(input int lo, input int hi);
		for (int i = lo; i < hi; i++) push_byte(rec_q[i]);
	endtask

	task automatic send_noise(input int n);
		repeat (n) push_byte(8'($urandom));
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_valid <= 1'b1;
		max_records <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic build_record(input bit bad_magic, input bit bad_version,
		input logic [15:0] ev, input logic [31:0] pay, input logic [31:0] meta,
		input logic [63:0] stamp);
		int pick;
		logic [7:0] v;
		rec_q.delete();
		for (int i = 0; i < 4; i++) rec_q.push_back(MAGIC_LE[8 * i +: 8]);
		if (bad_magic) begin
			pick = $urandom_range(3);
			rec_q[pick] = rec_q[pick] ^ 8'($urandom_range(1, 255));
		end
		v = GOOD_VERSION;
		if (bad_version) while (v == GOOD_VERSION) v = 8'($urandom);
		rec_q.push_back(v);
		rec_q.push_back(8'($urandom));
		for (int i = 0; i < 2; i++) rec_q.push_back(ev[8 * i +: 8]);
		for (int i = 0; i < 4; i++) rec_q.push_back(pay[8 * i +: 8]);
		for (int i = 0; i < 4; i++) rec_q.push_back(meta[8 * i +: 8]);
		for (int i = 0; i < 8; i++) rec_q.push_back(stamp[8 * i +: 8]);
		for (int i = 24; i < HEADER_BYTES; i++) rec_q.push_back(8'($urandom));
		repeat (32'(ev) + pay + meta) rec_q.push_back(8'($urandom));
	endtask

	function automatic logic [31:0] pick_len();
		int r;
		r = $urandom_range(9);
		if (r == 0) return '0;
		if (r < 8) return $urandom_range(1, 12);
		return $urandom_range(13, 60);
	endfunction

	task automatic random_record(output bit good);
		int r;
		bit bm;
		bit bv;
		r = $urandom_range(9);
		bm = (r == 0) || (r == 2);
		bv = (r == 1) || (r == 2);
		build_record(bm, bv, 16'(pick_len()), pick_len(), pick_len(),
			{$urandom, $urandom});
		send_span(0, rec_q.size());
		good = !bm && !bv;
	endtask

	initial begin : stimulus
		int sent;
		int goods;
		int cut;
		bit good;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		max_records = '0;
		in_valid = 1'b0;
		stream_byte = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all bodies empty, then bad magic, bad version, both, event only
		build_record(1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_span(0, rec_q.size());
		build_record(1'b1, 1'b0, 16'd1, 32'd0, 32'd2, 64'h0);
		send_span(0, rec_q.size());
		build_record(1'b0, 1'b1, 16'd0, 32'd3, 32'd0, {$urandom, $urandom});
		send_span(0, rec_q.size());
		build_record(1'b1, 1'b1, 16'd2, 32'd1, 32'd1, {$urandom, $urandom});
		send_span(0, rec_q.size());
		build_record(1'b0, 1'b0, 16'd2, 32'd0, 32'd0, {$urandom, $urandom});
		send_span(0, rec_q.size());

		// limit already reached, then zero limit, then the largest
		drain_pipeline();
		write_limit(16'd1);
		send_noise(5);
		drain_pipeline();
		write_limit(16'd0);
		send_noise(3);
		drain_pipeline();
		write_limit(16'hFFFF);

		// freeze partway through a record and resume it
		build_record(1'b0, 1'b0, 16'd3, 32'd2, 32'd1, {$urandom, $urandom});
		cut = $urandom_range(1, rec_q.size() - 1);
		send_span(0, cut);
		drain_pipeline();
		write_limit(tracker.accepted);
		send_noise(6);
		drain_pipeline();
		write_limit(16'hFFFF);
		send_span(cut, rec_q.size());

		sent = 0;
		while (sent < 150) begin
			random_record(good);
			sent += rec_q.size();
		end

		drain_pipeline();
		write_limit(16'($urandom_range(100, 65534)));
		send_gap_pct = 67;
		recv_gap_pct = 8;
		sent = 0;
		while (sent < 150) begin
			random_record(good);
			sent += rec_q.size();
		end

		// run into the limit, then bytes past it are dropped
		drain_pipeline();
		write_limit(tracker.accepted + 16'd1);
		send_gap_pct = 0;
		recv_gap_pct = 0;
		goods = 0;
		while (goods < 1) begin
			random_record(good);
			goods += good;
		end
		send_noise(10);

		drain_pipeline();
		if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
			$display("ledger_record_deframer: match");
		else
			$display("ledger_record_deframer: mismatch");
		$finish;
	end

endmodule
